[src/lpks_pkg.sv]
// ============================================================================
// lpks_pkg
// shared widths, codes and defaults for the last pressed key scanner
// ============================================================================
package lpks_pkg;

    localparam int KEY_FIELD_W = 7;
    localparam int STAMP_W     = 16;
    localparam int TIME_W      = 32;
    localparam int WINDOW_W    = 16;
    localparam int CODE_W      = 4;

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 8;

    localparam int DEFAULT_NUM_KEYS = 7;

    localparam logic [WINDOW_W-1:0] DEFAULT_EXIT_WINDOW = WINDOW_W'(100);

    localparam logic [CODE_W-1:0] CODE_NONE = CODE_W'(0);
    localparam logic [CODE_W-1:0] CODE_EXIT = CODE_W'(8);

    // control from the combo check to the key tracker
    typedef struct packed {
        logic advance;    // scan beat accepted this cycle
        logic hold_keys;  // exit combo hit, key state stays
    } lpks_step_t;

endpackage

[src/lpks_combo.sv]
// ============================================================================
// lpks_combo
// exit combo check: arming, start time capture and window compare
// ============================================================================
module lpks_combo
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [lpks_pkg::WINDOW_W-1:0] cfg_wr_data,
    input  logic                          advance,
    input  logic                          exit_a_level,
    input  logic                          exit_b_level,
    input  logic [lpks_pkg::TIME_W-1:0]   now_ms,
    output lpks_pkg::lpks_step_t          step
);
    import lpks_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic                armed_reg;
    logic                armed_next;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   start_next;
    logic [TIME_W-1:0]   elapsed;
    logic                any_low;
    logic                both_low;

    assign any_low  = ~exit_a_level | ~exit_b_level;
    assign both_low = ~exit_a_level & ~exit_b_level;

    always_comb
    begin
        armed_next = armed_reg;
        start_next = start_reg;
        if (any_low)
        begin
            armed_next = 1'b1;
            if (!armed_reg)
            begin
                start_next = now_ms;
            end
        end
        else
        begin
            armed_next = 1'b0;
        end
    end

    assign elapsed = now_ms - start_next;

    assign step.advance   = advance;
    assign step.hold_keys = both_low && (elapsed <= TIME_W'(window_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DEFAULT_EXIT_WINDOW;
        end
        else if (cfg_wr_en)
        begin
            window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            start_reg <= '0;
        end
        else if (advance)
        begin
            armed_reg <= armed_next;
            start_reg <= start_next;
        end
    end

endmodule

[src/lpks_track.sv]
// ============================================================================
// lpks_track
// per-key edge detect, press stamps and newest-held-key select
// ============================================================================
module lpks_track
#(
    parameter int NUM_KEYS = lpks_pkg::DEFAULT_NUM_KEYS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lpks_pkg::lpks_step_t             step,
    input  logic [lpks_pkg::KEY_FIELD_W-1:0] key_levels,
    output logic [lpks_pkg::CODE_W-1:0]      key_code
);
    import lpks_pkg::*;

    localparam int EXT_W   = (NUM_KEYS > KEY_FIELD_W) ? NUM_KEYS : KEY_FIELD_W;
    localparam int CNT_W   = $clog2(NUM_KEYS + 1);
    localparam int IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [EXT_W-1:0]    levels_ext;
    logic [NUM_KEYS-1:0] cur;
    logic [NUM_KEYS-1:0] fall;

    logic [NUM_KEYS-1:0] prev_reg;
    logic [NUM_KEYS-1:0] held_reg;
    logic [NUM_KEYS-1:0] held_next;
    logic [STAMP_W-1:0]  stamp_reg  [NUM_KEYS];
    logic [STAMP_W-1:0]  stamp_next [NUM_KEYS];
    logic [STAMP_W-1:0]  counter_reg;
    logic [STAMP_W-1:0]  counter_next;

    logic [CNT_W-1:0]    fall_cnt;
    logic                found;
    logic [IDX_W-1:0]    best;
    logic [STAMP_W-1:0]  best_stamp;

    // keys past the level field read as released
    assign levels_ext = EXT_W'({{EXT_W{1'b1}}, key_levels});
    assign cur        = levels_ext[NUM_KEYS-1:0];
    assign fall       = prev_reg & ~cur;

    always_comb
    begin
        fall_cnt = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            held_next[i]  = held_reg[i];
            stamp_next[i] = stamp_reg[i];
            if (fall[i])
            begin
                fall_cnt      = fall_cnt + CNT_W'(1);
                held_next[i]  = 1'b1;
                stamp_next[i] = counter_reg + STAMP_W'(fall_cnt);
            end
            else if (cur[i])
            begin
                held_next[i] = 1'b0;
            end
        end
        counter_next = counter_reg + STAMP_W'(fall_cnt);
        if (held_next == '0)
        begin
            counter_next = '0;
        end
    end

    // newest stamp wins, ties to the lower index
    always_comb
    begin
        found      = 1'b0;
        best       = '0;
        best_stamp = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (held_next[i] && (!found || stamp_next[i] > best_stamp))
            begin
                found      = 1'b1;
                best       = IDX_W'(i);
                best_stamp = stamp_next[i];
            end
        end
    end

    assign key_code = found ? (CODE_W'(best) + CODE_W'(1)) : CODE_NONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '1;
            held_reg    <= '0;
            counter_reg <= '0;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                stamp_reg[i] <= '0;
            end
        end
        else if (step.advance && !step.hold_keys)
        begin
            prev_reg    <= cur;
            held_reg    <= held_next;
            counter_reg <= counter_next;
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                stamp_reg[i] <= stamp_next[i];
            end
        end
    end

endmodule

[src/last_pressed_key_scanner.sv]
// ============================================================================
// last_pressed_key_scanner
// reports the most recently pressed held key, or the exit combo code
// ----------------------------------------------------------------------------
// one scan beat in on s_axis, one key code beat out on m_axis per scan.
// the scan is checked against the exit combo first (both exit keys low
// within exit_window_ms of arming gives code 8 and leaves key state alone);
// otherwise key falling edges are stamped and the newest held key is
// reported as index plus one, or 0 when nothing is held.
// the code is registered: it appears on m_axis the cycle after the
// scan beat is taken. throughput is one scan per clock while the receiver
// does not stall, set by the single output register; s_axis_tready stays
// high while that register is empty or being drained in the same cycle.
// when the receiver stalls the code is held in the output register and
// further scans are blocked until it is taken.
// reset releases all keys, clears held bits, stamps and the combo arming,
// empties the output register and sets exit_window_ms to 100.
// cfg_wr_en writes exit_window_ms; write it only while no beat is in flight.
// ============================================================================
module last_pressed_key_scanner
#(
    parameter int NUM_KEYS = lpks_pkg::DEFAULT_NUM_KEYS
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lpks_pkg::WINDOW_W-1:0]  cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // key_levels[6:0], exit_a_level[7], exit_b_level[8], now_ms[40:9], zero
    input  logic [lpks_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // key_code[3:0], zero
    output logic [lpks_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import lpks_pkg::*;

    logic                   advance;
    lpks_step_t             step;
    logic [CODE_W-1:0]      track_code;
    logic                   out_valid_reg;
    logic [CODE_W-1:0]      out_code_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign advance       = s_axis_tvalid && s_axis_tready;

    lpks_combo u_combo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .advance      (advance),
        .exit_a_level (s_axis_tdata[KEY_FIELD_W]),
        .exit_b_level (s_axis_tdata[KEY_FIELD_W+1]),
        .now_ms       (s_axis_tdata[KEY_FIELD_W+2 +: TIME_W]),
        .step         (step)
    );

    lpks_track #(.NUM_KEYS(NUM_KEYS)) u_track
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .key_levels (s_axis_tdata[KEY_FIELD_W-1:0]),
        .key_code   (track_code)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= step.hold_keys ? CODE_EXIT : track_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'(out_code_reg);

endmodule
